### rtl/core/gad_pkg.sv
package gad_pkg;

  // Default parameter values of the top level.
  localparam int RAW_BITS_DEF  = 16;
  localparam int PAD_COUNT_DEF = 2;

  // Fixed arithmetic widths. Magnitudes after the deadzone are Q1.30.
  localparam int MAG_W     = 31;
  localparam int DZ_QUO_W  = 31;
  localparam int ROOT_W    = 31;
  localparam int FIN_QUO_W = 15;
  localparam int FIN_DEN_W = 31;
  localparam int FIN_NUM_W = FIN_DEN_W + FIN_QUO_W;

  // Register stages from the input word to the result strobe.
  localparam int LATENCY = 1 + (DZ_QUO_W + 1) + 1 + (ROOT_W + 1) + 1 + (FIN_QUO_W + 1) + 1;

  // Operation codes.
  localparam logic [1:0] OP_STICK = 2'd0;
  localparam logic [1:0] OP_LTRIG = 2'd1;
  localparam logic [1:0] OP_RTRIG = 2'd2;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_DEADZONE = 3'd0;
  localparam logic [2:0] REG_UPPER    = 3'd1;
  localparam logic [2:0] REG_ENABLE   = 3'd2;
  localparam logic [2:0] REG_READY    = 3'd3;
  localparam logic [2:0] REG_AXES0    = 3'd4;
  localparam logic [2:0] REG_AXES1    = 3'd5;

  // Register reset values.
  localparam logic [15:0] DEADZONE_RST = 16'd19661;
  localparam logic [15:0] UPPER_RST    = 16'd49152;

  localparam logic [3:0]  STICK_MIN_AXES = 4'd2;
  localparam logic [3:0]  TRIG_MIN_AXES  = 4'd5;
  localparam logic [15:0] FULL_Q15       = 16'd32767;
  localparam logic [MAG_W-1:0] ONE_Q30   = 31'h4000_0000;

  // Flags that travel beside the deadzone division.
  typedef struct packed {
    logic pad;
    logic negx;
    logic negy;
    logic trig;
    logic zx;
    logic ox;
    logic zy;
    logic oy;
  } dz_side_t;

  // Flags and magnitudes that travel beside the square root.
  typedef struct packed {
    logic [MAG_W-1:0] ax;
    logic [MAG_W-1:0] ay;
    logic             norm;
    logic             big;
    logic             pad;
    logic             negx;
    logic             negy;
  } sq_side_t;

  // Flags that travel beside the final scaling division.
  typedef struct packed {
    logic pad;
    logic negx;
    logic negy;
    logic satx;
    logic saty;
    logic zero;
  } fin_side_t;

endpackage

### rtl/core/gamepad_axis_deadzone.sv
// Gamepad axis conditioning with an axial deadzone and radial saturation.
// Input channel: a word (operation, pad index, three raw axes) is taken at each
// rising edge where start is high and busy is low. busy stays low, so a new word
// may be given in every cycle; the pipeline sustains one word per cycle.
// Result channel: each word gives one result word, shown for one cycle with
// out_valid high. The receiver cannot hold results off and no holding is
// needed: words leave in the order taken.
// The pipeline holds the deadzone divider (32 stages), the square root
// (32 stages), the scaling divider (16 stages) and four single stages.
// Configuration: an APB-style port, register i at byte address 4*i, writes
// complete in the access cycle, pready is tied high. The user changes registers
// only while no word is in flight; the block does not enforce this.
// Reset (rst_n low, synchronous) empties the pipeline and loads the register
// reset values; no clearing pass is needed.
module gamepad_axis_deadzone #(
  parameter int RAW_BITS  = gad_pkg::RAW_BITS_DEF,
  parameter int PAD_COUNT = gad_pkg::PAD_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_operation,
  input  logic        in_pad_index,
  input  logic [15:0] in_raw_x,
  input  logic [15:0] in_raw_y,
  input  logic [15:0] in_raw_z,
  output logic        out_valid,
  output logic        out_pad_tag,
  output logic signed [15:0] out_x,
  output logic signed [15:0] out_y,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [RAW_BITS-1:0] RAW_MAX = {RAW_BITS{1'b1}};
  localparam int DEN_W    = RAW_BITS + 16;
  localparam int DZ_NUM_W = DEN_W + gad_pkg::DZ_QUO_W;
  localparam int MAG_W    = gad_pkg::MAG_W;
  localparam int FDEN_W   = gad_pkg::FIN_DEN_W;
  localparam int FNUM_W   = gad_pkg::FIN_NUM_W;

  // ---------------- Configuration registers ----------------
  logic [15:0] deadzone_r;
  logic [15:0] upper_r;
  logic        enable_r;
  logic [1:0]  ready_r;
  logic [3:0]  axes0_r;
  logic [3:0]  axes1_r;
  logic        cfg_wr;
  logic [2:0]  cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deadzone_r <= gad_pkg::DEADZONE_RST;
      upper_r    <= gad_pkg::UPPER_RST;
      enable_r   <= 1'b1;
      ready_r    <= 2'b00;
      axes0_r    <= 4'd0;
      axes1_r    <= 4'd0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        gad_pkg::REG_DEADZONE: deadzone_r <= pwdata[15:0];
        gad_pkg::REG_UPPER:    upper_r    <= pwdata[15:0];
        gad_pkg::REG_ENABLE:   enable_r   <= pwdata[0];
        gad_pkg::REG_READY:    ready_r    <= pwdata[1:0];
        gad_pkg::REG_AXES0:    axes0_r    <= pwdata[3:0];
        gad_pkg::REG_AXES1:    axes1_r    <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  // Read back.
  always_comb begin
    case (cfg_idx)
      gad_pkg::REG_DEADZONE: prdata = {16'd0, deadzone_r};
      gad_pkg::REG_UPPER:    prdata = {16'd0, upper_r};
      gad_pkg::REG_ENABLE:   prdata = {31'd0, enable_r};
      gad_pkg::REG_READY:    prdata = {30'd0, ready_r};
      gad_pkg::REG_AXES0:    prdata = {28'd0, axes0_r};
      gad_pkg::REG_AXES1:    prdata = {28'd0, axes1_r};
      default:               prdata = 32'd0;
    endcase
  end

  // Constants derived from the registers, refreshed every cycle.
  logic [DEN_W-1:0] sub_r, sub_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [DEN_W:0]   den_full;
  logic [59:0]      thr_r, thr_nxt;
  logic [31:0]      ud_sq;
  logic [29:0]      upq;

  always_comb begin
    sub_nxt  = {{RAW_BITS{1'b0}}, deadzone_r} * {16'd0, RAW_MAX};
    den_full = (DEN_W+1)'(17'h10000 - {1'b0, deadzone_r}) * (DEN_W+1)'(RAW_MAX);
    den_nxt  = den_full[DEN_W-1:0];
    ud_sq    = {16'd0, upper_r} * {16'd0, upper_r};
    thr_nxt  = {ud_sq, 28'd0};
    upq      = {upper_r, 14'd0};
  end

  always_ff @(posedge clk) begin
    sub_r <= sub_nxt;
    den_r <= den_nxt;
    thr_r <= thr_nxt;
  end

  // ---------------- Stage 1: gating and raw magnitudes ----------------
  function automatic logic [RAW_BITS:0] raw_mag(input logic [RAW_BITS-1:0] r);
    logic [RAW_BITS:0] two_r;
    logic [RAW_BITS:0] m;
    logic              pos;
    logic [RAW_BITS:0] mag;
    two_r = {r, 1'b0};
    m     = {1'b0, RAW_MAX};
    pos   = r[RAW_BITS-1];
    mag   = pos ? (two_r - m) : (m - two_r);
    return {pos, mag[RAW_BITS-1:0]};
  endfunction

  logic                accept;
  logic [RAW_BITS:0]   mx_in, my_in, mz_in;
  logic [3:0]          axes;
  logic                live, stick_ok, trig_ok;
  logic                v1_r;
  logic [RAW_BITS-1:0] absx_r, absy_r;
  logic                negx1_r, negy1_r, trig1_r, pad1_r;

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  always_comb begin
    mx_in    = raw_mag(in_raw_x[RAW_BITS-1:0]);
    my_in    = raw_mag(in_raw_y[RAW_BITS-1:0]);
    mz_in    = raw_mag(in_raw_z[RAW_BITS-1:0]);
    axes     = in_pad_index ? axes1_r : axes0_r;
    live     = enable_r & (int'(in_pad_index) < PAD_COUNT) & ready_r[in_pad_index];
    stick_ok = live & (in_operation == gad_pkg::OP_STICK) & (axes >= gad_pkg::STICK_MIN_AXES);
    trig_ok  = live & (axes >= gad_pkg::TRIG_MIN_AXES) &
               (((in_operation == gad_pkg::OP_LTRIG) & mz_in[RAW_BITS]) |
                ((in_operation == gad_pkg::OP_RTRIG) & ~mz_in[RAW_BITS]));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= accept;
    end
  end

  // A gated-off word enters with zero magnitudes, which give zero results.
  always_ff @(posedge clk) begin
    absx_r  <= stick_ok ? mx_in[RAW_BITS-1:0] : (trig_ok ? mz_in[RAW_BITS-1:0] : '0);
    absy_r  <= stick_ok ? my_in[RAW_BITS-1:0] : '0;
    negx1_r <= stick_ok & ~mx_in[RAW_BITS];
    negy1_r <= stick_ok & my_in[RAW_BITS];
    trig1_r <= trig_ok;
    pad1_r  <= in_pad_index;
  end

  // ---------------- Deadzone subtract and rescale division ----------------
  // Returns {zero, full, dividend}: below the deadzone, clamped at one, or divide.
  function automatic logic [DZ_NUM_W+1:0] dz_prep(input logic [RAW_BITS-1:0] a,
                                                 input logic [DEN_W-1:0] sub,
                                                 input logic [DEN_W-1:0] den);
    logic [DEN_W-1:0]    top;
    logic [DEN_W-1:0]    n;
    logic                zero;
    logic                full;
    logic [DZ_NUM_W-1:0] num;
    top  = {a, 16'd0};
    n    = top - sub;
    zero = (top <= sub);
    full = ~zero & (n >= den);
    num  = {1'b0, n, 30'd0} + DZ_NUM_W'(den >> 1);
    return {zero, full, num};
  endfunction

  logic [DZ_NUM_W+1:0]       prep_x, prep_y;
  logic [DZ_NUM_W-1:0]       dz_num [2];
  gad_pkg::dz_side_t         dz_side_in, dz_side_out;
  logic                      dz_v;
  logic [gad_pkg::DZ_QUO_W-1:0] dz_quo [2];

  always_comb begin
    prep_x          = dz_prep(absx_r, sub_r, den_r);
    prep_y          = dz_prep(absy_r, sub_r, den_r);
    dz_num[0]       = prep_x[DZ_NUM_W-1:0];
    dz_num[1]       = prep_y[DZ_NUM_W-1:0];
    dz_side_in.pad  = pad1_r;
    dz_side_in.negx = negx1_r;
    dz_side_in.negy = negy1_r;
    dz_side_in.trig = trig1_r;
    dz_side_in.zx   = prep_x[DZ_NUM_W+1];
    dz_side_in.ox   = prep_x[DZ_NUM_W];
    dz_side_in.zy   = prep_y[DZ_NUM_W+1];
    dz_side_in.oy   = prep_y[DZ_NUM_W];
  end

  gad_div #(
    .DEN_W  (DEN_W),
    .QUO_W  (gad_pkg::DZ_QUO_W),
    .LANES  (2),
    .SIDE_W ($bits(gad_pkg::dz_side_t))
  ) u_dz_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v1_r),
    .in_num    (dz_num),
    .in_den    (den_r),
    .in_side   (dz_side_in),
    .out_valid (dz_v),
    .out_quo   (dz_quo),
    .out_side  (dz_side_out)
  );

  // ---------------- Stage 3: squares ----------------
  logic [MAG_W-1:0] ax, ay;
  logic             v3_r;
  logic [MAG_W-1:0] ax3_r, ay3_r;
  logic [61:0]      sqx_r, sqy_r;
  logic             big3_r, trig3_r, pad3_r, negx3_r, negy3_r;

  always_comb begin
    ax = dz_side_out.zx ? '0 : (dz_side_out.ox ? gad_pkg::ONE_Q30 : dz_quo[0]);
    ay = dz_side_out.zy ? '0 : (dz_side_out.oy ? gad_pkg::ONE_Q30 : dz_quo[1]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= dz_v;
    end
  end

  always_ff @(posedge clk) begin
    ax3_r   <= ax;
    ay3_r   <= ay;
    sqx_r   <= 62'(ax) * 62'(ax);
    sqy_r   <= 62'(ay) * 62'(ay);
    big3_r  <= dz_side_out.trig & (ax > {1'b0, upq});
    trig3_r <= dz_side_out.trig;
    pad3_r  <= dz_side_out.pad;
    negx3_r <= dz_side_out.negx;
    negy3_r <= dz_side_out.negy;
  end

  // ---------------- Length test and square root ----------------
  logic [61:0]        len_sq;
  gad_pkg::sq_side_t  sq_side_in, sq_side_out;
  logic               sq_v;
  logic [gad_pkg::ROOT_W-1:0] root;

  always_comb begin
    len_sq          = sqx_r + sqy_r;
    sq_side_in.ax   = ax3_r;
    sq_side_in.ay   = ay3_r;
    sq_side_in.norm = ~trig3_r & (len_sq > {2'b00, thr_r});
    sq_side_in.big  = big3_r;
    sq_side_in.pad  = pad3_r;
    sq_side_in.negx = negx3_r;
    sq_side_in.negy = negy3_r;
  end

  gad_sqrt #(
    .ROOT_W (gad_pkg::ROOT_W),
    .SIDE_W ($bits(gad_pkg::sq_side_t))
  ) u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v3_r),
    .in_rad    (len_sq),
    .in_side   (sq_side_in),
    .out_valid (sq_v),
    .out_root  (root),
    .out_side  (sq_side_out)
  );

  // ---------------- Stage 5: divisor choice and rounded dividends ----------------
  logic [FDEN_W-1:0] dsel;
  logic              v5_r;
  logic [FDEN_W-1:0] d5_r;
  logic [FNUM_W-1:0] nx5_r, ny5_r;
  logic              big5_r, pad5_r, negx5_r, negy5_r;

  assign dsel = sq_side_out.norm ? root : {1'b0, upq};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else begin
      v5_r <= sq_v;
    end
  end

  // a*32767 is formed as a*32768 - a.
  always_ff @(posedge clk) begin
    d5_r    <= dsel;
    nx5_r   <= {sq_side_out.ax, 15'd0} - FNUM_W'(sq_side_out.ax) + FNUM_W'(dsel >> 1);
    ny5_r   <= {sq_side_out.ay, 15'd0} - FNUM_W'(sq_side_out.ay) + FNUM_W'(dsel >> 1);
    big5_r  <= sq_side_out.big;
    pad5_r  <= sq_side_out.pad;
    negx5_r <= sq_side_out.negx;
    negy5_r <= sq_side_out.negy;
  end

  // ---------------- Saturation test and scaling division ----------------
  logic [FNUM_W-1:0] dlim;
  logic              dzero;
  logic [FNUM_W-1:0] fin_num [2];
  logic [FDEN_W-1:0] fin_den;
  gad_pkg::fin_side_t fin_side_in, fin_side_out;
  logic              fin_v;
  logic [gad_pkg::FIN_QUO_W-1:0] fin_quo [2];

  always_comb begin
    dlim             = {d5_r, 15'd0};
    dzero            = (d5_r == '0);
    fin_num[0]       = nx5_r;
    fin_num[1]       = ny5_r;
    fin_den          = dzero ? FDEN_W'(1) : d5_r;
    fin_side_in.pad  = pad5_r;
    fin_side_in.negx = negx5_r;
    fin_side_in.negy = negy5_r;
    fin_side_in.satx = big5_r | (~dzero & (nx5_r >= dlim));
    fin_side_in.saty = ~dzero & (ny5_r >= dlim);
    fin_side_in.zero = dzero;
  end

  gad_div #(
    .DEN_W  (FDEN_W),
    .QUO_W  (gad_pkg::FIN_QUO_W),
    .LANES  (2),
    .SIDE_W ($bits(gad_pkg::fin_side_t))
  ) u_fin_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v5_r),
    .in_num    (fin_num),
    .in_den    (fin_den),
    .in_side   (fin_side_in),
    .out_valid (fin_v),
    .out_quo   (fin_quo),
    .out_side  (fin_side_out)
  );

  // ---------------- Output stage: saturation and sign ----------------
  logic [15:0] magx, magy;
  logic        out_valid_r;
  logic        out_pad_r;
  logic [15:0] out_x_r, out_y_r;

  always_comb begin
    magx = fin_side_out.satx ? gad_pkg::FULL_Q15 :
           (fin_side_out.zero ? 16'd0 : {1'b0, fin_quo[0]});
    magy = fin_side_out.saty ? gad_pkg::FULL_Q15 :
           (fin_side_out.zero ? 16'd0 : {1'b0, fin_quo[1]});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= fin_v;
    end
  end

  always_ff @(posedge clk) begin
    out_pad_r <= fin_side_out.pad;
    out_x_r   <= fin_side_out.negx ? (16'd0 - magx) : magx;
    out_y_r   <= fin_side_out.negy ? (16'd0 - magy) : magy;
  end

  assign out_valid   = out_valid_r;
  assign out_pad_tag = out_pad_r;
  assign out_x       = out_x_r;
  assign out_y       = out_y_r;

endmodule

### rtl/core/gad_div.sv
// Pipelined restoring divider, one quotient bit per stage, with a shared divisor.
// The quotient must be below 2**QUO_W, so the upper dividend part is below the divisor.
module gad_div #(
  parameter int DEN_W  = 32,
  parameter int QUO_W  = 31,
  parameter int LANES  = 2,
  parameter int SIDE_W = 1
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic [DEN_W+QUO_W-1:0]   in_num [LANES],
  input  logic [DEN_W-1:0]         in_den,
  input  logic [SIDE_W-1:0]        in_side,
  output logic                     out_valid,
  output logic [QUO_W-1:0]         out_quo [LANES],
  output logic [SIDE_W-1:0]        out_side
);

  logic              v_r    [QUO_W+1];
  logic [DEN_W-1:0]  den_r  [QUO_W+1];
  logic [SIDE_W-1:0] side_r [QUO_W+1];
  logic [DEN_W-1:0]  rem_r  [QUO_W+1][LANES];
  logic [QUO_W-1:0]  low_r  [QUO_W+1][LANES];

  // Entry stage holds the split dividend.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else begin
      v_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    den_r[0]  <= in_den;
    side_r[0] <= in_side;
    for (int l = 0; l < LANES; l++) begin
      rem_r[0][l] <= in_num[l][DEN_W+QUO_W-1:QUO_W];
      low_r[0][l] <= in_num[l][QUO_W-1:0];
    end
  end

  for (genvar k = 1; k <= QUO_W; k++) begin : g_stage
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else begin
        v_r[k] <= v_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      den_r[k]  <= den_r[k-1];
      side_r[k] <= side_r[k-1];
    end

    for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic [DEN_W:0]   trial;
      logic [DEN_W:0]   diff;
      logic             ge;
      logic [DEN_W-1:0] rem_nxt;
      logic [QUO_W-1:0] low_nxt;

      // Shift in the next dividend bit and subtract the divisor when it fits.
      always_comb begin
        trial   = {rem_r[k-1][l], low_r[k-1][l][QUO_W-1]};
        diff    = trial - {1'b0, den_r[k-1]};
        ge      = (trial >= {1'b0, den_r[k-1]});
        rem_nxt = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        low_nxt = {low_r[k-1][l][QUO_W-2:0], ge};
      end

      always_ff @(posedge clk) begin
        rem_r[k][l] <= rem_nxt;
        low_r[k][l] <= low_nxt;
      end
    end
  end

  assign out_valid = v_r[QUO_W];
  assign out_side  = side_r[QUO_W];
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      out_quo[l] = low_r[QUO_W][l];
    end
  end

endmodule

### rtl/core/gad_sqrt.sv
// Pipelined integer square root, one root bit per stage.
module gad_sqrt #(
  parameter int ROOT_W = 31,
  parameter int SIDE_W = 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic [2*ROOT_W-1:0]   in_rad,
  input  logic [SIDE_W-1:0]     in_side,
  output logic                  out_valid,
  output logic [ROOT_W-1:0]     out_root,
  output logic [SIDE_W-1:0]     out_side
);

  logic                v_r    [ROOT_W+1];
  logic [SIDE_W-1:0]   side_r [ROOT_W+1];
  logic [2*ROOT_W-1:0] rad_r  [ROOT_W+1];
  logic [ROOT_W+1:0]   rem_r  [ROOT_W+1];
  logic [ROOT_W-1:0]   root_r [ROOT_W+1];

  // Entry stage holds the radicand with an empty root.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else begin
      v_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    side_r[0] <= in_side;
    rad_r[0]  <= in_rad;
    rem_r[0]  <= '0;
    root_r[0] <= '0;
  end

  for (genvar k = 1; k <= ROOT_W; k++) begin : g_stage
    logic [ROOT_W+2:0]   trial;
    logic [ROOT_W+2:0]   sub;
    logic [ROOT_W+2:0]   diff;
    logic                ge;
    logic [ROOT_W+1:0]   rem_nxt;
    logic [ROOT_W-1:0]   root_nxt;
    logic [2*ROOT_W-1:0] rad_nxt;

    // Bring down two radicand bits and try the next root bit.
    always_comb begin
      trial    = {rem_r[k-1][ROOT_W:0], rad_r[k-1][2*ROOT_W-1:2*ROOT_W-2]};
      sub      = {1'b0, root_r[k-1], 2'b01};
      diff     = trial - sub;
      ge       = (trial >= sub);
      rem_nxt  = ge ? diff[ROOT_W+1:0] : trial[ROOT_W+1:0];
      root_nxt = {root_r[k-1][ROOT_W-2:0], ge};
      rad_nxt  = {rad_r[k-1][2*ROOT_W-3:0], 2'b00};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else begin
        v_r[k] <= v_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      side_r[k] <= side_r[k-1];
      rad_r[k]  <= rad_nxt;
      rem_r[k]  <= rem_nxt;
      root_r[k] <= root_nxt;
    end
  end

  assign out_valid = v_r[ROOT_W];
  assign out_root  = root_r[ROOT_W];
  assign out_side  = side_r[ROOT_W];

endmodule

### rtl/core/gad_checker.sv
// Port-level checks of the conditioning block.
module gad_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic [1:0]  in_operation,
  input logic        in_pad_index,
  input logic        out_valid,
  input logic        out_pad_tag,
  input logic [15:0] out_x,
  input logic [15:0] out_y
);

  localparam int LAT = gad_pkg::LATENCY;

  // Every word taken gives a result.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LAT out_valid)
    else $error("result missing after accepted word");

  // No result appears without a word taken at the matching time.
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LAT))
    else $error("result without an accepted word");

  // The tag follows its word through the pipeline.
  a_tag_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_pad_tag == $past(in_pad_index, LAT)))
    else $error("pad tag does not match its word");

  // Trigger and unknown operations never give a Y value or a negative X.
  a_trigger_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && ($past(in_operation, LAT) != gad_pkg::OP_STICK))
      |-> ((out_y == 16'd0) && !out_x[15]))
    else $error("non-stick result has Y or negative X");

endmodule

bind gamepad_axis_deadzone gad_checker u_gad_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .start        (start),
  .busy         (busy),
  .in_operation (in_operation),
  .in_pad_index (in_pad_index),
  .out_valid    (out_valid),
  .out_pad_tag  (out_pad_tag),
  .out_x        (out_x),
  .out_y        (out_y)
);
